// ----- rtl/core/pcg_pkg.sv -----
// Shared constants, types and CRC helper for the page CRC guard.
package pcg_pkg;
    localparam int unsigned PageCountDefault = 4096;
    localparam int unsigned QuarDepthDefault = 16;
    localparam logic [31:0] CrcPoly = 32'hEDB88320;
    localparam logic [31:0] CrcInit = 32'hFFFFFFFF;

    typedef enum logic [1:0] {
        OP_PROTECT   = 2'd0,
        OP_VERIFY    = 2'd1,
        OP_UNPROTECT = 2'd2,
        OP_CHECK     = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FAULT = 2'd1,
        ST_RANGE = 2'd2,
        ST_QUAR  = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]  operation;
        logic [19:0] page_number;
        logic [7:0]  data_byte;
        logic        last_byte;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] crc_value;
        logic        is_quarantined;
        logic        quarantine_added;
        logic [31:0] protected_count;
        logic [31:0] fault_count;
        logic [4:0]  quarantine_used;
    } t_out_word;

    // Page-end command handed from front to back.
    typedef struct packed {
        logic [1:0]  op;
        logic [19:0] page;
        logic [31:0] crc;
    } t_cmd;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
        end
        return c;
    endfunction
endpackage

// ----- rtl/core/pcg_if.sv -----
// Valid/ready stream interface for input and result words.
interface pcg_in_if;
    import pcg_pkg::*;
    logic     valid;
    logic     ready;
    t_in_word payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface pcg_out_if;
    import pcg_pkg::*;
    logic      valid;
    logic      ready;
    t_out_word payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/core/pcg_front.sv -----
// Front end: running CRC over streamed bytes, emits one command per page end or per unprotect/check word.
module pcg_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    pcg_in_if.sink         i_in,
    output logic           o_cmd_valid,
    output pcg_pkg::t_cmd  o_cmd,
    input  logic           i_cmd_ready
);
    import pcg_pkg::*;
    logic [31:0] r_crc;
    logic [31:0] n_crc;
    logic        take;
    logic        is_stream;

    assign i_in.ready = i_cmd_ready;
    assign take       = i_in.valid && i_cmd_ready;
    assign is_stream  = (i_in.payload.operation == OP_PROTECT) ||
                        (i_in.payload.operation == OP_VERIFY);
    assign n_crc      = crc_byte(r_crc, i_in.payload.data_byte);

    assign o_cmd_valid = i_in.valid && (!is_stream || i_in.payload.last_byte);
    assign o_cmd.op    = i_in.payload.operation;
    assign o_cmd.page  = i_in.payload.page_number;
    assign o_cmd.crc   = is_stream ? (n_crc ^ CrcInit) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= CrcInit;
        end else if (take && is_stream) begin
            r_crc <= i_in.payload.last_byte ? CrcInit : n_crc;
        end
    end
endmodule

// ----- rtl/core/pcg_queue.sv -----
// Two-entry command queue between front and back.
module pcg_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  pcg_pkg::t_cmd i_cmd,
    output logic          o_ready,
    output logic          o_valid,
    output pcg_pkg::t_cmd o_cmd,
    input  logic          i_ready
);
    import pcg_pkg::*;
    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

// ----- rtl/core/pcg_back.sv -----
// Back end: shadow table, quarantine list, counters and result register.
module pcg_back #(
    parameter int unsigned PAGE_COUNT       = pcg_pkg::PageCountDefault,
    parameter int unsigned QUARANTINE_DEPTH = pcg_pkg::QuarDepthDefault
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  pcg_pkg::t_cmd i_cmd,
    output logic          o_cmd_ready,
    pcg_out_if.source     o_out,
    output logic          o_busy
);
    import pcg_pkg::*;
    localparam int PW = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int QW = (QUARANTINE_DEPTH > 1) ? $clog2(QUARANTINE_DEPTH) : 1;
    localparam int FW = $clog2(QUARANTINE_DEPTH + 1);
    localparam int CW = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT + 1) : 1;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_READ, S_SEARCH, S_ACT, S_FINAL, S_OUT
    } t_state;

    t_state          r_state;
    logic [31:0]     r_shadow [PAGE_COUNT];
    logic [19:0]     r_qpages [QUARANTINE_DEPTH];
    logic [FW-1:0]   r_fill;
    logic [CW-1:0]   r_clr;
    logic [31:0]     r_prot;
    logic [31:0]     r_fault;
    t_cmd            r_cmd;
    logic [31:0]     r_rd;
    logic [FW-1:0]   r_idx;
    logic            r_hit;
    logic [1:0]      r_status;
    logic            r_added;
    logic            r_ovalid;
    t_out_word       r_out;
    logic            ranged;
    logic [PW-1:0]   pidx;
    logic [QW-1:0]   qidx;

    assign ranged      = ({12'd0, r_cmd.page} < 32'(PAGE_COUNT));
    assign pidx        = r_cmd.page[PW-1:0];
    assign qidx        = r_idx[QW-1:0];
    assign o_cmd_ready = (r_state == S_IDLE);
    assign o_busy      = (r_state != S_IDLE) || r_ovalid;
    assign o_out.valid   = r_ovalid;
    assign o_out.payload = r_out;

    // Shadow memory: one read port, one write port, registered read.
    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR) begin
            r_shadow[r_clr[PW-1:0]] <= 32'd0;
        end else if (r_state == S_ACT && ranged) begin
            case (r_cmd.op)
                OP_PROTECT:   if (!r_hit) r_shadow[pidx] <= r_cmd.crc;
                OP_UNPROTECT: r_shadow[pidx] <= 32'd0;
                default: ;
            endcase
        end
        if (r_state == S_READ) begin
            r_rd <= r_shadow[pidx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_ACT && r_cmd.op == OP_VERIFY && ranged && r_rd != 32'd0 &&
            r_rd != r_cmd.crc && r_fill < FW'(QUARANTINE_DEPTH)) begin
            r_qpages[r_fill[QW-1:0]] <= r_cmd.page;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_fill   <= '0;
            r_prot   <= '0;
            r_fault  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && o_out.ready) r_ovalid <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == CW'(PAGE_COUNT - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd   <= i_cmd;
                        r_idx   <= '0;
                        r_hit   <= 1'b0;
                        r_added <= 1'b0;
                        r_state <= S_READ;
                    end
                end
                S_READ: r_state <= S_SEARCH;
                S_SEARCH: begin
                    // One quarantine entry per cycle.
                    if (r_idx >= r_fill) begin
                        r_idx   <= '0;
                        r_state <= S_ACT;
                    end else begin
                        if (r_qpages[qidx] == r_cmd.page) r_hit <= 1'b1;
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_ACT: begin
                    r_state <= S_OUT;
                    case (r_cmd.op)
                        OP_PROTECT: begin
                            if (!ranged) r_status <= ST_RANGE;
                            else if (r_hit) r_status <= ST_QUAR;
                            else begin
                                r_status <= ST_OK;
                                r_prot   <= r_prot + 32'd1;
                            end
                        end
                        OP_VERIFY: begin
                            if (!ranged || r_rd == 32'd0) r_status <= ST_RANGE;
                            else if (r_rd != r_cmd.crc) begin
                                r_status <= ST_FAULT;
                                r_fault  <= r_fault + 32'd1;
                                if (r_fill < FW'(QUARANTINE_DEPTH)) begin
                                    r_fill  <= r_fill + 1'b1;
                                    r_added <= 1'b1;
                                    r_hit   <= 1'b1;
                                end
                            end else r_status <= ST_OK;
                        end
                        OP_UNPROTECT: begin
                            if (!ranged) r_status <= ST_RANGE;
                            else begin
                                r_status <= ST_OK;
                                if (r_prot != 32'd0) r_prot <= r_prot - 32'd1;
                            end
                        end
                        default: r_status <= ST_OK;
                    endcase
                end
                S_OUT: begin
                    if (!r_ovalid) begin
                        r_out.status           <= r_status;
                        r_out.crc_value        <= r_cmd.crc;
                        r_out.is_quarantined   <= r_hit;
                        r_out.quarantine_added <= r_added;
                        r_out.protected_count  <= r_prot;
                        r_out.fault_count      <= r_fault;
                        r_out.quarantine_used  <= 5'(r_fill);
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- rtl/core/page_crc_guard.sv -----
// Top level of the page CRC guard.
// Page CRC guard. Protect and verify words stream one byte per cycle, while
// the queue has room, into a reflected CRC32 in the front end; bytes that
// do not end a page produce no result. A page-end word (or an unprotect/check
// word) becomes a command that crosses a two-entry queue to the back end,
// which handles it with one shadow memory read, one quarantine compare per
// cycle for each filled quarantine entry, the update and the result register.
// Bytes of the next page keep flowing while the back end works, until the
// queue fills. After reset the back end clears the shadow table, one entry
// per cycle, during which no command leaves the queue; the front end keeps
// taking words until the queue is full.
// Only result words with status, CRC, quarantine flags and counters leave.
module page_crc_guard #(
    parameter int unsigned PAGE_COUNT       = pcg_pkg::PageCountDefault,
    parameter int unsigned QUARANTINE_DEPTH = pcg_pkg::QuarDepthDefault
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pcg_in_if.sink    i_in,
    pcg_out_if.source o_out
);
    import pcg_pkg::*;
    logic cmd_valid, cmd_ready, q_valid, q_ready, busy;
    t_cmd cmd, q_cmd;

    pcg_front u_front (
        .i_clk, .i_rst_n, .i_in,
        .o_cmd_valid (cmd_valid), .o_cmd (cmd), .i_cmd_ready (cmd_ready)
    );

    pcg_queue u_queue (
        .i_clk, .i_rst_n,
        .i_valid (cmd_valid), .i_cmd (cmd), .o_ready (cmd_ready),
        .o_valid (q_valid), .o_cmd (q_cmd), .i_ready (q_ready)
    );

    pcg_back #(.PAGE_COUNT(PAGE_COUNT), .QUARANTINE_DEPTH(QUARANTINE_DEPTH)) u_back (
        .i_clk, .i_rst_n,
        .i_cmd_valid (q_valid), .i_cmd (q_cmd), .o_cmd_ready (q_ready),
        .o_out, .o_busy (busy)
    );

    // Quarantine fill never exceeds the list depth.
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.payload.quarantine_used <= 5'(QUARANTINE_DEPTH))
        else $error("quarantine fill over depth");
    // An added page is always reported as quarantined and faulted.
    a_added: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.payload.quarantine_added) |->
        (o_out.payload.is_quarantined && o_out.payload.status == ST_FAULT))
        else $error("append without fault");
    // A pending result means the back end is busy.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> busy)
        else $error("result without busy");
endmodule
